### rtl/core/cra_pkg.sv
// Package for the contiguous region allocator: widths, codes, payload types.
package cra_pkg;

  localparam int CMD_W    = 3;
  localparam int TAG_W    = 32;
  localparam int SIZE_W   = 21;
  localparam int START_W  = 20;
  localparam int STAT_W   = 4;
  localparam int POL_W    = 2;
  localparam int CFG_W    = 21;
  localparam int CFG_IDX_W = 1;
  localparam int SPAN_W   = 22;
  localparam int ADDR_WIDTH = 20;
  localparam logic [SPAN_W-1:0] SPACE_CAP = SPAN_W'(1) << ADDR_WIDTH;

  localparam logic [CMD_W-1:0] CMD_REQUEST      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND         = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LIST_FREE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST_ASSIGNED = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI     = 3'd7;

  localparam logic [STAT_W-1:0] ST_ALLOCATED   = 4'd0;
  localparam logic [STAT_W-1:0] ST_REQ_FAILED  = 4'd1;
  localparam logic [STAT_W-1:0] ST_FREED       = 4'd2;
  localparam logic [STAT_W-1:0] ST_REL_FAILED  = 4'd3;
  localparam logic [STAT_W-1:0] ST_FOUND       = 4'd4;
  localparam logic [STAT_W-1:0] ST_FAULT       = 4'd5;
  localparam logic [STAT_W-1:0] ST_HOLE        = 4'd6;
  localparam logic [STAT_W-1:0] ST_REGION      = 4'd7;
  localparam logic [STAT_W-1:0] ST_NONE        = 4'd8;
  localparam logic [STAT_W-1:0] ST_FULL        = 4'd9;

  localparam logic [POL_W-1:0] POL_BEST  = 2'd0;
  localparam logic [POL_W-1:0] POL_WORST = 2'd1;
  localparam logic [POL_W-1:0] POL_FIRST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [TAG_W-1:0]   result_tag;
    logic [SIZE_W-1:0]  result_size;
    logic [START_W-1:0] result_start;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  size;
    logic [START_W-1:0] start;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_INSERT,
    S_CLOSE,
    S_REPLY
  } state_t;

  function automatic out_t mk_out(logic [STAT_W-1:0] st, logic [TAG_W-1:0] tg,
                                  logic [SIZE_W-1:0] sz, logic [START_W-1:0] sa,
                                  logic lst);
    out_t o;
    o.status       = st;
    o.result_tag   = tg;
    o.result_size  = sz;
    o.result_start = sa;
    o.last         = lst;
    return o;
  endfunction

endpackage

### rtl/core/contiguous_region_allocator.sv
// Contiguous region allocator: start-sorted region table in one synchronous memory.
//
//   channel | direction | handshake          | payload
//   cfg     | in        | cfg_we             | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall  | in_data (cra_pkg::in_t)
//   out     | out       | out_valid/out_stall| out_data (cra_pkg::out_t)
//
// A command scans the table one entry per cycle through the memory read port;
// a request then moves entries up to open a slot, a release moves entries down.
// Items are taken one at a time.
// Reset clears the region count and the output valid flag; the table needs no clear.
// A stalled output holds the scan in place until the transfer goes through.
module contiguous_region_allocator #(
  parameter int MAX_REGIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cra_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cra_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cra_pkg::out_t                  out_data
);

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_REGIONS);

  cra_pkg::state_t state, state_next;

  logic [cra_pkg::POL_W-1:0]  fit_policy;
  logic [cra_pkg::SIZE_W-1:0] total_size;

  logic [cra_pkg::CMD_W-1:0]  cmd_q, cmd_q_next;
  logic [cra_pkg::TAG_W-1:0]  tag_q, tag_q_next;
  logic [cra_pkg::SIZE_W-1:0] n_q, n_q_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] p, p_next;
  logic [CW-1:0] pick, pick_next;
  logic [CW-1:0] j, j_next;
  logic [cra_pkg::SPAN_W-1:0] prev_end, prev_end_next;
  logic [cra_pkg::SPAN_W-1:0] pick_len, pick_len_next;
  logic [cra_pkg::SPAN_W-1:0] pick_base, pick_base_next;
  logic have, have_next;
  logic hold_v, hold_v_next;
  cra_pkg::out_t rep, rep_next;

  cra_pkg::entry_t mem [MAX_REGIONS];
  cra_pkg::entry_t rdata, wdata;
  logic [IW-1:0] raddr, waddr;
  logic ren, wen;

  logic out_load;
  cra_pkg::out_t out_load_data;
  logic out_free;

  logic [cra_pkg::SPAN_W-1:0] space, hi, g, ent_end;
  logic ent_v, scan_last, adv, done, hit;
  logic [CW-1:0] p_inc;
  logic [CW:0] j_plus2;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= cra_pkg::POL_BEST;
      total_size <= cra_pkg::SIZE_W'(1048576);
    end else if (cfg_we) begin
      case (cfg_index)
        cra_pkg::REG_FIT_POLICY: fit_policy <= cfg_data[cra_pkg::POL_W-1:0];
        cra_pkg::REG_TOTAL_SIZE: total_size <= cfg_data[cra_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cra_pkg::S_IDLE;
      count  <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q     <= cmd_q_next;
    tag_q     <= tag_q_next;
    n_q       <= n_q_next;
    p         <= p_next;
    pick      <= pick_next;
    j         <= j_next;
    prev_end  <= prev_end_next;
    pick_len  <= pick_len_next;
    pick_base <= pick_base_next;
    have      <= have_next;
    hold_v    <= hold_v_next;
    rep       <= rep_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_load_data;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign space = (cra_pkg::SPAN_W'(total_size) < cra_pkg::SPACE_CAP) ?
                 cra_pkg::SPAN_W'(total_size) : cra_pkg::SPACE_CAP;
  assign ent_v     = (p < count);
  assign scan_last = (p == count);
  assign hi      = ent_v ? cra_pkg::SPAN_W'(rdata.start) : space;
  assign g       = (hi > prev_end) ? (hi - prev_end) : '0;
  assign ent_end = cra_pkg::SPAN_W'(rdata.start) + cra_pkg::SPAN_W'(rdata.size);
  assign p_inc   = p + CW'(1);
  assign j_plus2 = {1'b0, j} + (CW+1)'(2);
  assign hit     = ent_v && (rdata.tag == tag_q);

  always_comb begin
    state_next     = state;
    cmd_q_next     = cmd_q;
    tag_q_next     = tag_q;
    n_q_next       = n_q;
    count_next     = count;
    p_next         = p;
    pick_next      = pick;
    j_next         = j;
    prev_end_next  = prev_end;
    pick_len_next  = pick_len;
    pick_base_next = pick_base;
    have_next      = have;
    hold_v_next    = hold_v;
    rep_next       = rep;
    ren            = 1'b0;
    raddr          = '0;
    wen            = 1'b0;
    waddr          = '0;
    wdata          = rdata;
    out_load       = 1'b0;
    out_load_data  = rep;
    adv            = 1'b1;
    done           = 1'b0;
    in_stall       = (state != cra_pkg::S_IDLE);

    case (state)
      cra_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_q_next    = in_data.command;
          tag_q_next    = in_data.tag;
          n_q_next      = in_data.size;
          p_next        = '0;
          prev_end_next = '0;
          have_next     = 1'b0;
          hold_v_next   = 1'b0;
          ren           = 1'b1;
          raddr         = '0;
          case (in_data.command)
            cra_pkg::CMD_REQUEST: begin
              if (in_data.size == '0 ||
                  cra_pkg::SPAN_W'(in_data.size) > space || count >= MAX_COUNT) begin
                rep_next   = cra_pkg::mk_out(cra_pkg::ST_REQ_FAILED, in_data.tag,
                                             in_data.size, '0, 1'b1);
                state_next = cra_pkg::S_REPLY;
              end else begin
                state_next = cra_pkg::S_SCAN;
              end
            end
            cra_pkg::CMD_RELEASE, cra_pkg::CMD_FIND,
            cra_pkg::CMD_LIST_FREE, cra_pkg::CMD_LIST_ASSIGNED: begin
              state_next = cra_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end

      cra_pkg::S_SCAN: begin
        case (cmd_q)
          cra_pkg::CMD_REQUEST: begin
            if (g >= cra_pkg::SPAN_W'(n_q)) begin
              if (!have) begin
                have_next      = 1'b1;
                pick_next      = p;
                pick_len_next  = g;
                pick_base_next = prev_end;
                if (fit_policy != cra_pkg::POL_BEST && fit_policy != cra_pkg::POL_WORST) begin
                  done = 1'b1;
                end
              end else if ((fit_policy == cra_pkg::POL_BEST && g < pick_len) ||
                           (fit_policy == cra_pkg::POL_WORST && g > pick_len)) begin
                pick_next      = p;
                pick_len_next  = g;
                pick_base_next = prev_end;
              end
            end
            if (scan_last) begin
              done = 1'b1;
            end
            if (done) begin
              adv = 1'b0;
              if (!have_next) begin
                rep_next   = cra_pkg::mk_out(cra_pkg::ST_REQ_FAILED, tag_q, n_q, '0, 1'b1);
                state_next = cra_pkg::S_REPLY;
              end else if (count > pick_next) begin
                ren        = 1'b1;
                raddr      = IW'(count - CW'(1));
                j_next     = count;
                state_next = cra_pkg::S_SHIFT;
              end else begin
                state_next = cra_pkg::S_INSERT;
              end
            end
          end

          cra_pkg::CMD_RELEASE, cra_pkg::CMD_FIND: begin
            if (hit) begin
              adv = 1'b0;
              if (cmd_q == cra_pkg::CMD_FIND) begin
                rep_next   = cra_pkg::mk_out(cra_pkg::ST_FOUND, tag_q, rdata.size,
                                             rdata.start, 1'b1);
                state_next = cra_pkg::S_REPLY;
              end else begin
                rep_next = cra_pkg::mk_out(cra_pkg::ST_FREED, tag_q, rdata.size,
                                           rdata.start, 1'b1);
                if (p_inc < count) begin
                  ren        = 1'b1;
                  raddr      = IW'(p_inc);
                  j_next     = p;
                  state_next = cra_pkg::S_CLOSE;
                end else begin
                  count_next = count - CW'(1);
                  state_next = cra_pkg::S_REPLY;
                end
              end
            end else if (scan_last) begin
              adv        = 1'b0;
              rep_next   = cra_pkg::mk_out((cmd_q == cra_pkg::CMD_FIND) ? cra_pkg::ST_FAULT :
                                           cra_pkg::ST_REL_FAILED, tag_q, '0, '0, 1'b1);
              state_next = cra_pkg::S_REPLY;
            end
          end

          cra_pkg::CMD_LIST_FREE: begin
            if (g != '0) begin
              if (hold_v && !out_free) begin
                adv = 1'b0;
              end else begin
                if (hold_v) begin
                  out_load      = 1'b1;
                  out_load_data = rep;
                end
                rep_next    = cra_pkg::mk_out(cra_pkg::ST_HOLE, '0, g[cra_pkg::SIZE_W-1:0],
                                              prev_end[cra_pkg::START_W-1:0], 1'b0);
                hold_v_next = 1'b1;
              end
            end
            if (adv && scan_last) begin
              if (hold_v_next) begin
                rep_next.last = 1'b1;
              end else begin
                rep_next = cra_pkg::mk_out(cra_pkg::ST_FULL, '0, '0, '0, 1'b1);
              end
              state_next = cra_pkg::S_REPLY;
            end
          end

          cra_pkg::CMD_LIST_ASSIGNED: begin
            if (ent_v) begin
              if (!out_free) begin
                adv = 1'b0;
              end else begin
                out_load      = 1'b1;
                out_load_data = cra_pkg::mk_out(cra_pkg::ST_REGION, rdata.tag, rdata.size,
                                                rdata.start, p_inc == count);
              end
            end else if (count == '0) begin
              rep_next   = cra_pkg::mk_out(cra_pkg::ST_NONE, '0, '0, '0, 1'b1);
              state_next = cra_pkg::S_REPLY;
            end else begin
              state_next = cra_pkg::S_IDLE;
            end
          end

          default: state_next = cra_pkg::S_IDLE;
        endcase

        // advance to the next entry while the scan goes on
        if (adv && state_next == cra_pkg::S_SCAN) begin
          p_next        = p_inc;
          prev_end_next = ent_end;
          ren           = 1'b1;
          raddr         = (p_inc < count) ? IW'(p_inc) : '0;
        end
      end

      cra_pkg::S_SHIFT: begin
        wen    = 1'b1;
        waddr  = IW'(j);
        wdata  = rdata;
        j_next = j - CW'(1);
        if ((j - CW'(1)) > pick) begin
          ren   = 1'b1;
          raddr = IW'(j - CW'(2));
        end else begin
          state_next = cra_pkg::S_INSERT;
        end
      end

      cra_pkg::S_INSERT: begin
        wen         = 1'b1;
        waddr       = IW'(pick);
        wdata.tag   = tag_q;
        wdata.size  = n_q;
        wdata.start = pick_base[cra_pkg::START_W-1:0];
        count_next  = count + CW'(1);
        rep_next    = cra_pkg::mk_out(cra_pkg::ST_ALLOCATED, tag_q, n_q,
                                      pick_base[cra_pkg::START_W-1:0], 1'b1);
        state_next  = cra_pkg::S_REPLY;
      end

      cra_pkg::S_CLOSE: begin
        wen    = 1'b1;
        waddr  = IW'(j);
        wdata  = rdata;
        j_next = j + CW'(1);
        if (j_plus2 < {1'b0, count}) begin
          ren   = 1'b1;
          raddr = IW'(j_plus2);
        end else begin
          count_next = count - CW'(1);
          state_next = cra_pkg::S_REPLY;
        end
      end

      cra_pkg::S_REPLY: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_data = rep;
          state_next    = cra_pkg::S_IDLE;
        end
      end

      default: state_next = cra_pkg::S_IDLE;
    endcase
  end

endmodule

### rtl/core/cra_checker.sv
// Port-level checker for the contiguous region allocator, bound to the allocator module.
module cra_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input cra_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input cra_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.command <= cra_pkg::CMD_LIST_ASSIGNED |=> in_stall)
    else $error("input taken again before command finished");

  a_mid_list_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |->
      (out_data.status == cra_pkg::ST_HOLE || out_data.status == cra_pkg::ST_REGION))
    else $error("non-final result outside a list");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind contiguous_region_allocator cra_checker u_cra_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### verif/tb_top.sv
// Testbench for the contiguous region allocator: directed and randomized command traffic checked by a predictor.
module tb_top;

  localparam int TABLE_DEPTH = 16;
  localparam int IDLE_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [cra_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cra_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  cra_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cra_pkg::out_t out_data;

  contiguous_region_allocator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [cra_pkg::POL_W-1:0] pol_m;
  logic [cra_pkg::SIZE_W-1:0] total_m;
  cra_pkg::entry_t tbl_m [TABLE_DEPTH];
  int count_m;
  cra_pkg::out_t expected_q [$];
  int errors = 0;
  int idle_cycles = 0;
  int rx_hold_left = 0;
  bit hold_rx = 1'b0;
  bit stall_quiet = 1'b0;
  logic [cra_pkg::TAG_W-1:0] live_tags [$];

  function automatic logic [cra_pkg::SPAN_W-1:0] span_total();
    return (cra_pkg::SPAN_W'(total_m) < cra_pkg::SPACE_CAP) ?
           cra_pkg::SPAN_W'(total_m) : cra_pkg::SPACE_CAP;
  endfunction

  function automatic logic [cra_pkg::SPAN_W-1:0] gap_base(int k);
    if (k == 0) return '0;
    return cra_pkg::SPAN_W'(tbl_m[k-1].start) + cra_pkg::SPAN_W'(tbl_m[k-1].size);
  endfunction

  function automatic logic [cra_pkg::SPAN_W-1:0] gap_len(int k);
    logic [cra_pkg::SPAN_W-1:0] lo, hi;
    lo = gap_base(k);
    hi = (k < count_m) ? cra_pkg::SPAN_W'(tbl_m[k].start) : span_total();
    return (hi > lo) ? hi - lo : '0;
  endfunction

  function automatic int find_tag(logic [cra_pkg::TAG_W-1:0] tg);
    for (int i = 0; i < count_m; i++) if (tbl_m[i].tag == tg) return i;
    return -1;
  endfunction

  task automatic predict_allocation(cra_pkg::in_t it);
    bit have;
    int pick, idx, k;
    logic [cra_pkg::SPAN_W-1:0] pick_len, g, n;
    have = 0; pick = 0; pick_len = '0; n = cra_pkg::SPAN_W'(it.size);
    case (it.command)
      cra_pkg::CMD_REQUEST: begin
        if (n == 0 || n > span_total() || count_m >= TABLE_DEPTH) begin
          expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_REQ_FAILED, it.tag, it.size,
                                               '0, 1'b1));
          return;
        end
        for (int i = 0; i <= count_m; i++) begin
          g = gap_len(i);
          if (g < n) continue;
          if (!have) begin
            have = 1; pick = i; pick_len = g;
            if (pol_m >= cra_pkg::POL_FIRST) break;
          end else if ((pol_m == cra_pkg::POL_BEST && g < pick_len) ||
                       (pol_m == cra_pkg::POL_WORST && g > pick_len)) begin
            pick = i; pick_len = g;
          end
        end
        if (!have) begin
          expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_REQ_FAILED, it.tag, it.size,
                                               '0, 1'b1));
          return;
        end
        g = gap_base(pick);
        for (int i = count_m; i > pick; i--) tbl_m[i] = tbl_m[i-1];
        tbl_m[pick] = '{tag: it.tag, size: it.size, start: cra_pkg::START_W'(g)};
        count_m++;
        expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_ALLOCATED, it.tag, it.size,
                                             cra_pkg::START_W'(g), 1'b1));
      end
      cra_pkg::CMD_RELEASE: begin
        idx = find_tag(it.tag);
        if (idx < 0) begin
          expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_REL_FAILED, it.tag, '0, '0, 1'b1));
          return;
        end
        expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_FREED, it.tag, tbl_m[idx].size,
                                             tbl_m[idx].start, 1'b1));
        for (int i = idx; i + 1 < count_m; i++) tbl_m[i] = tbl_m[i+1];
        count_m--;
      end
      cra_pkg::CMD_FIND: begin
        idx = find_tag(it.tag);
        if (idx < 0) expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_FAULT, it.tag, '0, '0,
                                                          1'b1));
        else expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_FOUND, it.tag, tbl_m[idx].size,
                                                  tbl_m[idx].start, 1'b1));
      end
      cra_pkg::CMD_LIST_FREE: begin
        k = 0;
        for (int i = 0; i <= count_m; i++) begin
          g = gap_len(i);
          if (g > 0) begin
            expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_HOLE, '0, cra_pkg::SIZE_W'(g),
                                                 cra_pkg::START_W'(gap_base(i)), 1'b0));
            k++;
          end
        end
        if (k == 0) expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_FULL, '0, '0, '0, 1'b1));
        else expected_q[$].last = 1'b1;
      end
      cra_pkg::CMD_LIST_ASSIGNED: begin
        if (count_m == 0)
          expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_NONE, '0, '0, '0, 1'b1));
        for (int i = 0; i < count_m; i++)
          expected_q.push_back(cra_pkg::mk_out(cra_pkg::ST_REGION, tbl_m[i].tag, tbl_m[i].size,
                                               tbl_m[i].start, i + 1 == count_m));
      end
      default: ;
    endcase
  endtask

  task automatic short_gap(int max_long);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, max_long) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_command(logic [cra_pkg::CMD_W-1:0] cmd, logic [cra_pkg::TAG_W-1:0] tg,
                              logic [cra_pkg::SIZE_W-1:0] sz, bit gaps = 1'b1);
    cra_pkg::in_t it;
    it.command = cmd; it.tag = tg; it.size = sz;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_allocation(it);
    if (cmd == cra_pkg::CMD_REQUEST && sz != 0) live_tags.push_back(tg);
    @(negedge clk);
    in_valid <= 1'b0;
    if (gaps) short_gap(30);
  endtask

  task automatic drain();
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [cra_pkg::CFG_IDX_W-1:0] idx,
                           logic [cra_pkg::CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == cra_pkg::REG_FIT_POLICY) pol_m = val[cra_pkg::POL_W-1:0];
    else total_m = val;
  endtask

  function automatic logic [cra_pkg::TAG_W-1:0] pick_tag();
    if (live_tags.size() != 0 && $urandom_range(0, 3) != 0)
      return live_tags[$urandom_range(0, live_tags.size() - 1)];
    return $urandom();
  endfunction

  // receiver: mostly short random stalls, now and then a long one, long hold when asked, none while quiet
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold_left <= 0;
    end else if (hold_rx) begin
      out_stall <= 1'b1;
    end else if (stall_quiet) begin
      out_stall <= 1'b0;
    end else if (rx_hold_left != 0) begin
      out_stall <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if ($urandom_range(0, 39) == 0) begin
      out_stall <= 1'b1;
      rx_hold_left <= $urandom_range(5, 30);
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          if (out_data !== expected_q[0])
            $display("%0t: mismatch expected %p actual %p", $time, expected_q[0], out_data);
          if (out_data !== expected_q[0]) errors++;
          void'(expected_q.pop_front());
        end
      end
    end
  end

  task automatic test_directed();
    write_reg(cra_pkg::REG_FIT_POLICY, cra_pkg::CFG_W'(cra_pkg::POL_BEST));
    send_command(cra_pkg::CMD_LIST_ASSIGNED, '0, '0);
    send_command(cra_pkg::CMD_LIST_FREE, '0, '0);
    send_command(cra_pkg::CMD_REQUEST, 32'hFFFF_FFFF, '0);
    send_command(cra_pkg::CMD_REQUEST, 32'h0, 21'h1F_FFFF);
    send_command(cra_pkg::CMD_REQUEST, 32'h0, 21'd1048576);
    send_command(cra_pkg::CMD_LIST_FREE, '0, '0);
    send_command(cra_pkg::CMD_RELEASE, 32'h0, '0);
    send_command(cra_pkg::CMD_FIND, 32'h0, '0);
    send_command(cra_pkg::CMD_REQUEST, 32'hAAAA_5555, 21'd100);
    send_command(cra_pkg::CMD_REQUEST, 32'hAAAA_5555, 21'd50);
    send_command(cra_pkg::CMD_FIND, 32'hAAAA_5555, '0);
    send_command(cra_pkg::CMD_RELEASE, 32'h1234_5678, '0);
    send_command(cra_pkg::CMD_FIND, 32'h1234_5678, '0);
    send_command(cra_pkg::CMD_SPARE_LO, 32'hFFFF_FFFF, 21'h1F_FFFF);
    send_command(cra_pkg::CMD_SPARE_HI, '0, '0);
    send_command(cra_pkg::CMD_LIST_ASSIGNED, '0, '0);
    send_command(cra_pkg::CMD_RELEASE, 32'hAAAA_5555, '0);
    send_command(cra_pkg::CMD_LIST_FREE, '0, '0);
    send_command(cra_pkg::CMD_RELEASE, 32'hAAAA_5555, '0);
  endtask

  task automatic test_policies();
    for (int p = 0; p < 4; p++) begin
      write_reg(cra_pkg::REG_FIT_POLICY, cra_pkg::CFG_W'(p));
      write_reg(cra_pkg::REG_TOTAL_SIZE, cra_pkg::CFG_W'(200));
      while (count_m != 0) send_command(cra_pkg::CMD_RELEASE, tbl_m[0].tag, '0, 1'b0);
      send_command(cra_pkg::CMD_REQUEST, 32'h1, 21'd10, 1'b0);
      send_command(cra_pkg::CMD_REQUEST, 32'h2, 21'd30, 1'b0);
      send_command(cra_pkg::CMD_REQUEST, 32'h3, 21'd10, 1'b0);
      send_command(cra_pkg::CMD_REQUEST, 32'h4, 21'd20, 1'b0);
      send_command(cra_pkg::CMD_RELEASE, 32'h1, '0, 1'b0);
      send_command(cra_pkg::CMD_RELEASE, 32'h3, '0, 1'b0);
      send_command(cra_pkg::CMD_REQUEST, 32'h5, 21'd5, 1'b0);
      send_command(cra_pkg::CMD_LIST_FREE, '0, '0, 1'b0);
      send_command(cra_pkg::CMD_LIST_ASSIGNED, '0, '0, 1'b0);
    end
    // shrink below the regions in place
    write_reg(cra_pkg::REG_TOTAL_SIZE, cra_pkg::CFG_W'(20));
    send_command(cra_pkg::CMD_LIST_FREE, '0, '0);
    send_command(cra_pkg::CMD_REQUEST, 32'h6, 21'd1);
    write_reg(cra_pkg::REG_TOTAL_SIZE, cra_pkg::CFG_W'(1));
  endtask

  task automatic test_full_table();
    write_reg(cra_pkg::REG_TOTAL_SIZE, cra_pkg::CFG_W'(1048576));
    write_reg(cra_pkg::REG_FIT_POLICY, cra_pkg::CFG_W'(cra_pkg::POL_FIRST));
    while (count_m < TABLE_DEPTH)
      send_command(cra_pkg::CMD_REQUEST, $urandom(), cra_pkg::SIZE_W'($urandom_range(1, 4)));
    send_command(cra_pkg::CMD_REQUEST, 32'hFEED, 21'd1);
    send_command(cra_pkg::CMD_LIST_FREE, '0, '0);
    send_command(cra_pkg::CMD_LIST_ASSIGNED, '0, '0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(negedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_command(cra_pkg::CMD_LIST_ASSIGNED, '0, '0, 1'b0);
    join
    drain();
  endtask

  task automatic test_random(int n_items);
    int r;
    logic [cra_pkg::CMD_W-1:0] cmd;
    logic [cra_pkg::SIZE_W-1:0] sz;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        write_reg(cra_pkg::REG_FIT_POLICY, cra_pkg::CFG_W'($urandom_range(0, 3)));
        r = $urandom_range(0, 3);
        write_reg(cra_pkg::REG_TOTAL_SIZE, (r == 0) ? cra_pkg::CFG_W'($urandom()) :
                  (r == 1) ? cra_pkg::CFG_W'(1048576) :
                  cra_pkg::CFG_W'($urandom_range(1, 4000)));
      end
      if (i == 40) stall_quiet = 1'b1;
      if (i == 60) stall_quiet = 1'b0;
      r = $urandom_range(0, 99);
      cmd = (r < 40) ? cra_pkg::CMD_REQUEST : (r < 65) ? cra_pkg::CMD_RELEASE :
            (r < 80) ? cra_pkg::CMD_FIND : (r < 88) ? cra_pkg::CMD_LIST_FREE :
            (r < 96) ? cra_pkg::CMD_LIST_ASSIGNED :
            cra_pkg::CMD_W'($urandom_range(cra_pkg::CMD_SPARE_LO, cra_pkg::CMD_SPARE_HI));
      r = $urandom_range(0, 19);
      sz = (r == 0) ? cra_pkg::SIZE_W'($urandom()) : (r == 1) ? '0 :
           cra_pkg::SIZE_W'($urandom_range(1, 600));
      send_command(cmd, pick_tag(), sz, i % 50 < 45);
    end
  endtask

  initial begin
    pol_m = cra_pkg::POL_BEST; total_m = 21'd1048576; count_m = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_policies();
    test_full_table();
    test_backpressure();
    test_random(80);
    drain();
    if (errors == 0 && expected_q.size() == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule

### contiguous_region_allocator.f
rtl/core/cra_pkg.sv
rtl/core/contiguous_region_allocator.sv
rtl/core/cra_checker.sv
verif/tb_top.sv
